// File: sv/fcdl_pkg.sv
// fcdl_pkg: shared types and defaults of the front-coded dictionary lookup
// used by front_coded_dictionary_lookup; no dependencies
`timescale 1ns / 1ps

package fcdl_pkg;

   localparam int unsigned DictBytesDef = 65536;
   localparam int unsigned MaxWordDef   = 32;
   localparam int unsigned MaxPhonesDef = 32;

   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 16;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ENTRY_COUNT    = 3'd0,
      CSR_BUCKET_COUNT   = 3'd1,
      CSR_BUCKET_ENTRIES = 3'd2,
      CSR_INDEX_BASE     = 3'd3,
      CSR_HEADS_BASE     = 3'd4,
      CSR_ENTRIES_BASE   = 3'd5
   } csr_idx_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_START,
      S_SEARCH,
      S_HEAD_SH,
      S_HEAD_WL,
      S_HEAD_BYTE,
      S_INDEX,
      S_BUCKET,
      S_ENT_H0,
      S_ENT_H1,
      S_ENT_SUF,
      S_ENT_PH,
      S_CMP_INIT,
      S_CMP,
      S_EMIT_INIT,
      S_EMIT,
      S_RESP
   } state_type;

endpackage

// File: sv/front_coded_dictionary_lookup.sv
// front_coded_dictionary_lookup: dictionary byte memory, query buffer and lookup sequencer
// depends on fcdl_pkg
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// req      in         req_valid/req_ready  kind, load_address, data_byte, word_end
// rsp      out        rsp_valid/rsp_ready  found, phone_total, phone_code, stress_mark, final_res
// csr      in         csr_we               csr_index, csr_wdata
//
// a load or a non-final query character is taken in S_IDLE and the sequencer stays idle
// a lookup reads one memory byte per cycle: per probe it walks head words 0..mid
// (prefix byte, length byte, then each new byte) and then compares up to MAX_WORD characters,
// binary search over about log2(bucket_count) probes; then 4 index bytes and the
// bucket entries byte by byte
// reset is synchronous; the memories hold no reset state, the query length clears
// req_ready is low from a final character until the last result item is taken

module front_coded_dictionary_lookup
   import fcdl_pkg::*;
#(
   parameter int unsigned DICT_BYTES = DictBytesDef,
   parameter int unsigned MAX_WORD   = MaxWordDef,
   parameter int unsigned MAX_PHONES = MaxPhonesDef
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [15:0]         req_load_address,
   input  logic [7:0]          req_data_byte,
   input  logic                req_word_end,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [4:0]          rsp_phone_total,
   output logic [5:0]          rsp_phone_code,
   output logic [1:0]          rsp_stress_mark,
   output logic                rsp_final_res,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam int unsigned AW  = $clog2(DICT_BYTES);
   localparam int unsigned QIW = $clog2(MAX_WORD);
   localparam int unsigned QLW = $clog2(MAX_WORD + 2);
   localparam int unsigned PIW = $clog2(MAX_PHONES);

   logic [7:0] dict_mem  [DICT_BYTES];
   logic [7:0] query_mem [MAX_WORD];
   logic [7:0] word_mem  [MAX_WORD];
   logic [7:0] phone_mem [MAX_PHONES];

   state_type state_ff, state_in;

   logic [15:0]   entry_count_ff;
   logic [11:0]   bucket_count_ff;
   logic [7:0]    bucket_entries_ff;
   logic [15:0]   index_base_ff;
   logic [15:0]   heads_base_ff;
   logic [15:0]   entries_base_ff;

   logic [AW-1:0]  addr_ff, addr_in;
   logic [7:0]     q_ff;
   logic [7:0]     qc_ff, dw_ff, ph_ff;
   logic [QLW-1:0] qlen_ff, qlen_in;
   logic [QLW-1:0] dlen_ff, dlen_in;
   logic [QLW-1:0] ci_ff, ci_in;
   logic [11:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, hb_ff, hb_in;
   logic [7:0]     k_ff, k_in, wl_ff, wl_in;
   logic [4:0]     np_ff, np_in, npc_ff, npc_in, pi_ff, pi_in;
   logic           in_bkt_ff, in_bkt_in, found_ff, found_in;
   logic [31:0]    off_ff, off_in;
   logic [1:0]     jb_ff, jb_in;
   logic [19:0]    first_ff, first_in;
   logic [7:0]     cnt_ff, cnt_in, ec_ff, ec_in;

   logic           dw_we, ph_we;
   logic [7:0]     wr_byte;
   logic [QLW-1:0] cmp_n;
   logic           cmp_done, cmp_lt, cmp_eq;
   logic [11:0]    bidx;
   logic [15:0]    rem_cnt;
   logic [31:0]    ent_addr;
   logic [QLW-1:0] wl_cut;
   logic [4:0]     np_cut;

   assign bidx    = lo_ff - 12'd1;
   assign cmp_n   = (dlen_ff < qlen_ff) ? dlen_ff : qlen_ff;
   assign rem_cnt = (20'(entry_count_ff) > first_ff) ? entry_count_ff - first_ff[15:0] : 16'd0;
   assign ent_addr = 32'(entries_base_ff) + off_ff;
   assign wl_cut  = (wl_ff > 8'(MAX_WORD)) ? QLW'(MAX_WORD) : QLW'(wl_ff);
   assign np_cut  = (32'(np_ff) > MAX_PHONES) ? 5'(MAX_PHONES) : np_ff;
   assign wr_byte = q_ff;

   always_comb begin
      cmp_done = 1'b0;
      cmp_lt   = 1'b0;
      cmp_eq   = 1'b0;
      if (ci_ff == cmp_n) begin
         cmp_done = 1'b1;
         cmp_lt   = dlen_ff < qlen_ff;
         cmp_eq   = dlen_ff == qlen_ff;
      end else if (dw_ff != qc_ff) begin
         cmp_done = 1'b1;
         cmp_lt   = dw_ff < qc_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_kind && req_word_end) state_in = S_START;
         end
         S_START: begin
            if (qlen_ff == '0 || 32'(qlen_ff) > MAX_WORD) state_in = S_RESP;
            else state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) state_in = S_HEAD_SH;
            else if (lo_ff == '0) state_in = S_RESP;
            else state_in = S_INDEX;
         end
         S_HEAD_SH:   state_in = S_HEAD_WL;
         S_HEAD_WL:   state_in = S_HEAD_BYTE;
         S_HEAD_BYTE: begin
            if (k_ff >= wl_ff) state_in = (hb_ff == mid_ff) ? S_CMP_INIT : S_HEAD_SH;
         end
         S_INDEX: begin
            if (jb_ff == 2'd3) state_in = S_BUCKET;
         end
         S_BUCKET: begin
            state_in = (rem_cnt == '0 || bucket_entries_ff == '0) ? S_RESP : S_ENT_H0;
         end
         S_ENT_H0:  state_in = S_ENT_H1;
         S_ENT_H1:  state_in = S_ENT_SUF;
         S_ENT_SUF: begin
            if (k_ff >= wl_ff) state_in = S_ENT_PH;
         end
         S_ENT_PH: begin
            if (k_ff >= 8'(np_ff)) state_in = S_CMP_INIT;
         end
         S_CMP_INIT: state_in = S_CMP;
         S_CMP: begin
            if (cmp_done) begin
               if (!in_bkt_ff) state_in = S_SEARCH;
               else if (cmp_eq) state_in = (np_cut == '0) ? S_RESP : S_EMIT_INIT;
               else if (ec_ff + 8'd1 == cnt_ff) state_in = S_RESP;
               else state_in = S_ENT_H0;
            end
         end
         S_EMIT_INIT: state_in = S_EMIT;
         S_EMIT: begin
            if (rsp_ready && pi_ff == npc_ff - 5'd1) state_in = S_IDLE;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      addr_in   = addr_ff;
      qlen_in   = qlen_ff;
      dlen_in   = dlen_ff;
      ci_in     = ci_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      hb_in     = hb_ff;
      k_in      = k_ff;
      wl_in     = wl_ff;
      np_in     = np_ff;
      npc_in    = npc_ff;
      pi_in     = pi_ff;
      in_bkt_in = in_bkt_ff;
      found_in  = found_ff;
      off_in    = off_ff;
      jb_in     = jb_ff;
      first_in  = first_ff;
      cnt_in    = cnt_ff;
      ec_in     = ec_ff;
      dw_we     = 1'b0;
      ph_we     = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_found       = 1'b0;
      rsp_phone_total = '0;
      rsp_phone_code  = '0;
      rsp_stress_mark = '0;
      rsp_final_res   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_kind) begin
               if (32'(qlen_ff) < MAX_WORD) qlen_in = qlen_ff + QLW'(1);
               else qlen_in = QLW'(MAX_WORD + 1);
            end
         end
         S_START: begin
            found_in  = 1'b0;
            in_bkt_in = 1'b0;
            lo_in     = '0;
            hi_in     = bucket_count_ff;
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in  = lo_ff + ((hi_ff - lo_ff) >> 1);
               hb_in   = '0;
               addr_in = AW'(heads_base_ff);
            end else begin
               addr_in = AW'(32'(index_base_ff) + {18'd0, bidx, 2'b00});
               jb_in   = '0;
            end
         end
         S_HEAD_SH: begin
            k_in    = q_ff;
            addr_in = addr_ff + AW'(1);
         end
         S_HEAD_WL: begin
            wl_in   = q_ff;
            addr_in = addr_ff + AW'(1);
         end
         S_HEAD_BYTE: begin
            if (k_ff < wl_ff) begin
               dw_we   = k_ff < 8'(MAX_WORD);
               addr_in = addr_ff + AW'(1);
               k_in    = k_ff + 8'd1;
            end else begin
               dlen_in = wl_cut;
               hb_in   = hb_ff + 12'd1;
            end
         end
         S_INDEX: begin
            off_in   = {q_ff, off_ff[31:8]};
            addr_in  = addr_ff + AW'(1);
            jb_in    = jb_ff + 2'd1;
            first_in = bidx * bucket_entries_ff;
         end
         S_BUCKET: begin
            addr_in   = ent_addr[AW-1:0];
            cnt_in    = (rem_cnt > 16'(bucket_entries_ff)) ? bucket_entries_ff : rem_cnt[7:0];
            ec_in     = '0;
            in_bkt_in = 1'b1;
         end
         S_ENT_H0: begin
            wl_in   = q_ff;
            addr_in = addr_ff + AW'(1);
         end
         S_ENT_H1: begin
            k_in    = {3'd0, wl_ff[4:0]};
            wl_in   = {3'd0, q_ff[1:0], wl_ff[7:5]};
            np_in   = q_ff[6:2];
            addr_in = addr_ff + AW'(1);
         end
         S_ENT_SUF: begin
            if (k_ff < wl_ff) begin
               dw_we   = k_ff < 8'(MAX_WORD);
               addr_in = addr_ff + AW'(1);
               k_in    = k_ff + 8'd1;
            end else begin
               dlen_in = wl_cut;
               k_in    = '0;
            end
         end
         S_ENT_PH: begin
            if (k_ff < 8'(np_ff)) begin
               ph_we   = k_ff < 8'(MAX_PHONES);
               addr_in = addr_ff + AW'(1);
               k_in    = k_ff + 8'd1;
            end
         end
         S_CMP_INIT: begin
            ci_in = '0;
         end
         S_CMP: begin
            if (!cmp_done) ci_in = ci_ff + QLW'(1);
            else if (!in_bkt_ff) begin
               if (cmp_lt || cmp_eq) lo_in = mid_ff + 12'd1;
               else hi_in = mid_ff;
            end else if (cmp_eq) begin
               found_in = 1'b1;
               npc_in   = np_cut;
            end else begin
               ec_in = ec_ff + 8'd1;
            end
         end
         S_EMIT_INIT: begin
            pi_in = '0;
         end
         S_EMIT: begin
            rsp_valid       = 1'b1;
            rsp_found       = 1'b1;
            rsp_phone_total = npc_ff;
            rsp_phone_code  = ph_ff[5:0];
            rsp_stress_mark = ph_ff[7:6];
            rsp_final_res   = pi_ff == npc_ff - 5'd1;
            if (rsp_ready) begin
               pi_in = pi_ff + 5'd1;
               if (rsp_final_res) qlen_in = '0;
            end
         end
         S_RESP: begin
            rsp_valid     = 1'b1;
            rsp_found     = found_ff;
            rsp_final_res = 1'b1;
            if (rsp_ready) qlen_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid && !req_kind) begin
         dict_mem[AW'(req_load_address)] <= req_data_byte;
      end
      q_ff <= dict_mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid && req_kind && 32'(qlen_ff) < MAX_WORD) begin
         query_mem[qlen_ff[QIW-1:0]] <= req_data_byte;
      end
      qc_ff <= query_mem[ci_in[QIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (dw_we) word_mem[k_ff[QIW-1:0]] <= wr_byte;
      dw_ff <= word_mem[ci_in[QIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ph_we) phone_mem[k_ff[PIW-1:0]] <= wr_byte;
      ph_ff <= phone_mem[pi_in[PIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff    <= '0;
         bucket_count_ff   <= '0;
         bucket_entries_ff <= 8'd1;
         index_base_ff     <= '0;
         heads_base_ff     <= '0;
         entries_base_ff   <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_ENTRY_COUNT:    entry_count_ff    <= csr_wdata;
            CSR_BUCKET_COUNT:   bucket_count_ff   <= csr_wdata[11:0];
            CSR_BUCKET_ENTRIES: bucket_entries_ff <= csr_wdata[7:0];
            CSR_INDEX_BASE:     index_base_ff     <= csr_wdata;
            CSR_HEADS_BASE:     heads_base_ff     <= csr_wdata;
            CSR_ENTRIES_BASE:   entries_base_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         qlen_ff   <= '0;
         in_bkt_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         qlen_ff   <= qlen_in;
         in_bkt_ff <= in_bkt_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      dlen_ff  <= dlen_in;
      ci_ff    <= ci_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      hb_ff    <= hb_in;
      k_ff     <= k_in;
      wl_ff    <= wl_in;
      np_ff    <= np_in;
      npc_ff   <= npc_in;
      pi_ff    <= pi_in;
      off_ff   <= off_in;
      jb_ff    <= jb_in;
      first_ff <= first_in;
      cnt_ff   <= cnt_in;
      ec_ff    <= ec_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("result item shown while input is open");

   a_qlen_range: assert property (@(posedge clock) disable iff (reset)
      32'(qlen_ff) <= MAX_WORD + 1)
      else $error("query length out of range");

   a_cmp_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> (ci_ff <= qlen_ff && ci_ff <= dlen_ff))
      else $error("compare index past word end");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HEAD_SH |-> (mid_ff < hi_ff && hb_ff <= mid_ff))
      else $error("head walk past probe");
endmodule
